// File: rtl/cabn_pkg.sv
// Package with shared constants, types and the sequencer states of the box suppression block.
package cabn_pkg;

  localparam int unsigned MaxBoxes   = 64;
  localparam int unsigned NumClasses = 6;
  localparam logic [15:0] IouReset   = 16'd29491;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN,
    ST_BEST_RD,
    ST_EMIT,
    ST_CMP_RD,
    ST_CMP_AREA,
    ST_CMP_PROD,
    ST_CMP_PROD_B,
    ST_CMP_PROD_I,
    ST_CMP_MUL,
    ST_CMP_DEC,
    ST_NEXT_CLASS
  } state_e;

endpackage

// File: rtl/cabn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cabn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/class_aware_box_nms.sv
// Top level of the class-aware box non-maximum suppression block.
// Boxes are taken one per cycle while loading; a box carrying frame_end starts suppression,
// and stall_o stays high until the last kept box of the frame sits in the output register.
// Each kept box is held back by one kept box so that the last one can carry run_end. For each
// class the sequencer scans all N stored boxes to find the best survivor, reads the winner and
// takes it once the output register is not held, then runs one shared multiplier over all
// N boxes: each box gets an area step and a decision step, and each box still live in that
// class also gets three product steps and a union step in between. A class ends when a scan
// finds no survivor or no box is stored. All box data sits in one memory with a single read
// port that paces the scans.
module class_aware_box_nms #(
  parameter int unsigned MaxBoxes   = cabn_pkg::MaxBoxes,
  parameter int unsigned NumClasses = cabn_pkg::NumClasses
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] box_left_i,
  input  logic signed [15:0] box_top_i,
  input  logic signed [15:0] box_right_i,
  input  logic signed [15:0] box_bottom_i,
  input  logic [5:0]         class_id_i,
  input  logic [15:0]        score_i,
  input  logic               frame_end_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] kept_left_o,
  output logic signed [15:0] kept_top_o,
  output logic signed [15:0] kept_right_o,
  output logic signed [15:0] kept_bottom_o,
  output logic [5:0]         kept_class_o,
  output logic [15:0]        kept_score_o,
  output logic               run_end_o,
  output logic               overflowed_o
);

  localparam int unsigned IdxW = $clog2(MaxBoxes);
  localparam int unsigned CntW = $clog2(MaxBoxes + 1);
  localparam int unsigned EntW = 64 + 6 + 16;

  cabn_pkg::state_e state_q, state_d;

  logic [15:0]         thr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic [MaxBoxes-1:0] sup_q, sup_d;
  logic [5:0]          cls_q, cls_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]     best_q, best_d;
  logic                found_q, found_d;
  logic [15:0]         bsc_q, bsc_d;
  logic [63:0]         bcor_q, bcor_d;
  logic                any_q, any_d;
  logic [EntW-1:0]     pend_q, pend_d;

  logic                out_v_q, out_v_d;
  logic [EntW-1:0]     out_q, out_d;
  logic                out_end_q, out_end_d;
  logic                out_ovf_q, out_ovf_d;

  // Overlap pipeline registers.
  logic signed [33:0]  s1_q, s2_q, in_q, s1_d, s2_d, in_d;
  logic signed [16:0]  iw_q, ih_q, aw_q, ah_q, bw_q, bh_q, iw_d, ih_d, aw_d, ah_d, bw_d, bh_d;
  logic                neg_q, neg_d;
  logic signed [35:0]  uni_q, uni_d;

  // The one multiplier shared by all products of the overlap test.
  logic signed [35:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [52:0]  mul_p;

  logic                we;
  logic [IdxW-1:0]     raddr;
  logic [EntW-1:0]     wdata, rdata;
  logic                take;

  cabn_ram #(.Width(EntW), .Depth(MaxBoxes)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic cls_ok;
  assign cls_ok = ({1'b0, class_id_i} < 7'(NumClasses));

  assign wdata = {score_i, class_id_i, box_bottom_i, box_right_i, box_top_i, box_left_i};
  assign take  = valid_i && !stall_o;
  assign we    = take && cls_ok && (cnt_q < CntW'(MaxBoxes));
  assign mul_p = mul_a * mul_b;

  logic [15:0] r_sc;
  logic [5:0]  r_cl;
  logic signed [15:0] al, at, ar, ab, bl, bt, br, bb, il, it, ir, ib;
  assign r_sc = rdata[85:70];
  assign r_cl = rdata[69:64];
  assign al = bcor_q[15:0];
  assign at = bcor_q[31:16];
  assign ar = bcor_q[47:32];
  assign ab = bcor_q[63:48];
  assign bl = rdata[15:0];
  assign bt = rdata[31:16];
  assign br = rdata[47:32];
  assign bb = rdata[63:48];
  assign il = (al > bl) ? al : bl;
  assign it = (at > bt) ? at : bt;
  assign ir = (ar < br) ? ar : br;
  assign ib = (ab < bb) ? ab : bb;

  logic live;
  assign live = !sup_q[idx_q] && (r_cl == cls_q);

  logic last_idx;
  assign last_idx = ({1'b0, idx_q} == CntW'(cnt_q - 1'b1));

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d; s2_q <= s2_d; in_q <= in_d;
    iw_q <= iw_d; ih_q <= ih_d; aw_q <= aw_d; ah_q <= ah_d; bw_q <= bw_d; bh_q <= bh_d;
    neg_q <= neg_d; uni_q <= uni_d;
    bcor_q <= bcor_d; bsc_q <= bsc_d; out_q <= out_d; pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cabn_pkg::ST_LOAD;
      thr_q     <= cabn_pkg::IouReset;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      sup_q     <= '0;
      cls_q     <= '0;
      idx_q     <= '0;
      best_q    <= '0;
      found_q   <= 1'b0;
      any_q     <= 1'b0;
      out_v_q   <= 1'b0;
      out_end_q <= 1'b0;
      out_ovf_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      sup_q     <= sup_d;
      cls_q     <= cls_d;
      idx_q     <= idx_d;
      best_q    <= best_d;
      found_q   <= found_d;
      any_q     <= any_d;
      out_v_q   <= out_v_d;
      out_end_q <= out_end_d;
      out_ovf_q <= out_ovf_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; ovf_d = ovf_q; sup_d = sup_q; cls_d = cls_q; idx_d = idx_q;
    best_d = best_q; found_d = found_q; bsc_d = bsc_q; bcor_d = bcor_q; any_d = any_q;
    pend_d = pend_q;
    out_v_d = out_v_q; out_d = out_q; out_end_d = out_end_q; out_ovf_d = out_ovf_q;
    s1_d = s1_q; s2_d = s2_q; in_d = in_q; iw_d = iw_q; ih_d = ih_q;
    aw_d = aw_q; ah_d = ah_q; bw_d = bw_q; bh_d = bh_q;
    neg_d = neg_q; uni_d = uni_q;
    mul_a = '0;
    mul_b = '0;
    raddr = idx_q;
    stall_o = 1'b1;
    if (out_v_q && !stall_i) begin
      out_v_d = 1'b0;
    end
    case (state_q)
      cabn_pkg::ST_LOAD: begin
        stall_o = 1'b0;
        if (take) begin
          if (cls_ok) begin
            if (cnt_q < CntW'(MaxBoxes)) begin
              cnt_d = cnt_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (frame_end_i) begin
            cls_d = '0;
            idx_d = '0;
            found_d = 1'b0;
            any_d = 1'b0;
            state_d = cabn_pkg::ST_SCAN_RD;
          end
        end
      end
      cabn_pkg::ST_SCAN_RD: begin
        if (cnt_q == '0) begin
          state_d = cabn_pkg::ST_NEXT_CLASS;
        end else begin
          state_d = cabn_pkg::ST_SCAN;
        end
      end
      cabn_pkg::ST_SCAN: begin
        if (live && (!found_q || r_sc > bsc_q)) begin
          found_d = 1'b1;
          best_d = idx_q;
          bsc_d = r_sc;
        end
        if (last_idx) begin
          raddr = (live && (!found_q || r_sc > bsc_q)) ? idx_q : best_q;
          state_d = (live || found_q) ? cabn_pkg::ST_BEST_RD : cabn_pkg::ST_NEXT_CLASS;
        end else begin
          idx_d = idx_q + 1'b1;
          raddr = idx_q + 1'b1;
        end
      end
      cabn_pkg::ST_BEST_RD: begin
        raddr = best_q;
        state_d = cabn_pkg::ST_EMIT;
      end
      cabn_pkg::ST_EMIT: begin
        // The previous kept box moves to the output register and the new one waits, so that
        // the last kept box of the frame can be marked.
        raddr = best_q;
        if (!any_q || !out_v_q || !stall_i) begin
          if (any_q) begin
            out_v_d = 1'b1;
            out_end_d = 1'b0;
            out_d = pend_q;
            out_ovf_d = ovf_q;
          end
          pend_d = rdata;
          any_d = 1'b1;
          bcor_d = rdata[63:0];
          sup_d[best_q] = 1'b1;
          idx_d = '0;
          raddr = '0;
          state_d = cabn_pkg::ST_CMP_RD;
        end
      end
      cabn_pkg::ST_CMP_RD: begin
        raddr = idx_q;
        state_d = cabn_pkg::ST_CMP_AREA;
      end
      cabn_pkg::ST_CMP_AREA: begin
        raddr = idx_q;
        aw_d = 17'(ar) - 17'(al); ah_d = 17'(ab) - 17'(at);
        bw_d = 17'(br) - 17'(bl); bh_d = 17'(bb) - 17'(bt);
        iw_d = 17'(ir) - 17'(il); ih_d = 17'(ib) - 17'(it);
        neg_d = (it > ib) || (il > ir);
        if (!live) begin
          state_d = cabn_pkg::ST_CMP_DEC;
          neg_d = 1'b1;
          uni_d = '0;
          in_d = '0;
        end else begin
          state_d = cabn_pkg::ST_CMP_PROD;
        end
      end
      cabn_pkg::ST_CMP_PROD: begin
        mul_a = 36'(aw_q);
        mul_b = ah_q;
        s1_d = 34'(mul_p);
        state_d = cabn_pkg::ST_CMP_PROD_B;
      end
      cabn_pkg::ST_CMP_PROD_B: begin
        mul_a = 36'(bw_q);
        mul_b = bh_q;
        s2_d = 34'(mul_p);
        state_d = cabn_pkg::ST_CMP_PROD_I;
      end
      cabn_pkg::ST_CMP_PROD_I: begin
        mul_a = 36'(iw_q);
        mul_b = ih_q;
        in_d = neg_q ? 34'sd0 : 34'(mul_p);
        state_d = cabn_pkg::ST_CMP_MUL;
      end
      cabn_pkg::ST_CMP_MUL: begin
        uni_d = 36'(s1_q) + 36'(s2_q) - 36'(in_q);
        state_d = cabn_pkg::ST_CMP_DEC;
        neg_d = 1'b0;
      end
      cabn_pkg::ST_CMP_DEC: begin
        mul_a = uni_q;
        mul_b = $signed({1'b0, thr_q});
        if (!neg_q) begin
          if (uni_q <= 0) begin
            if (thr_q == '0) begin
              sup_d[idx_q] = 1'b1;
            end
          end else if ((54'(in_q) <<< 16) >= 54'(mul_p)) begin
            sup_d[idx_q] = 1'b1;
          end
        end
        if (last_idx) begin
          idx_d = '0;
          found_d = 1'b0;
          state_d = cabn_pkg::ST_SCAN_RD;
          raddr = '0;
        end else begin
          idx_d = idx_q + 1'b1;
          raddr = idx_q + 1'b1;
          state_d = cabn_pkg::ST_CMP_AREA;
        end
      end
      cabn_pkg::ST_NEXT_CLASS: begin
        raddr = '0;
        if (cls_q == 6'(NumClasses - 1)) begin
          if (!any_q) begin
            cnt_d = '0; ovf_d = 1'b0; sup_d = '0;
            state_d = cabn_pkg::ST_LOAD;
          end else if (!out_v_q || !stall_i) begin
            out_v_d = 1'b1;
            out_end_d = 1'b1;
            out_d = pend_q;
            out_ovf_d = ovf_q;
            cnt_d = '0; ovf_d = 1'b0; sup_d = '0;
            state_d = cabn_pkg::ST_LOAD;
          end
        end else begin
          cls_d = cls_q + 1'b1;
          idx_d = '0;
          found_d = 1'b0;
          state_d = cabn_pkg::ST_SCAN_RD;
        end
      end
      default: state_d = cabn_pkg::ST_LOAD;
    endcase
  end

  assign valid_o       = out_v_q;
  assign kept_left_o   = out_q[15:0];
  assign kept_top_o    = out_q[31:16];
  assign kept_right_o  = out_q[47:32];
  assign kept_bottom_o = out_q[63:48];
  assign kept_class_o  = out_q[69:64];
  assign kept_score_o  = out_q[85:70];
  assign run_end_o     = out_end_q;
  assign overflowed_o  = out_ovf_q;

endmodule
